// ----- design/bhlfs_pkg.sv -----
// ----------------------------------------------------------------------------
// bhlfs_pkg
// Shared types and constants of the byte histogram log fill score block.
// ----------------------------------------------------------------------------
`default_nettype none

package bhlfs_pkg;

  localparam int NUM_BINS    = 256;
  localparam int BIN_W       = 8;
  localparam int SCORE_W     = 11;   // holds 100*log10(2^48) rounded
  localparam int SQR_STEPS   = 16;
  localparam int STEP_W      = 4;
  localparam int QUO_W       = 7;    // a normalised percentage is at most 100
  localparam int KCNT_W      = 3;
  localparam int SUM_W       = 15;
  localparam int PCT_W       = 7;
  localparam int MANT_W      = 31;   // q1.30 mantissa below 2.0
  localparam logic [14:0] LOG10_2_Q16 = 15'd19728;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_END   = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [6:0]  fill_percent;
    logic [31:0] bin_count;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_QRY,
    ST_RD,
    ST_LOAD,
    ST_NORM,
    ST_SQR,
    ST_L10,
    ST_SCORE,
    ST_DCHK,
    ST_DRD,
    ST_DLD,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic cnt_rd_in;
    logic cap_idx;
    logic cnt_wr;
    logic clr_valid;
    logic load_x;
    logic norm;
    logic load_m;
    logic sqr;
    logic calc_l10;
    logic calc_score;
    logic bin_clr;
    logic bin_inc;
    logic max_clr;
    logic sum_clr;
    logic div_ld;
    logic div_step;
    logic sum_add;
    logic out_query;
    logic out_fill;
  } cmd_t;

  typedef struct packed {
    logic x_top;
    logic sqr_last;
    logic div_last;
    logic bin_last;
    logic max_zero;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/bhlfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// bhlfs_ctrl
// Sequencer for request decode, histogram update and the end-of-file passes.
// ----------------------------------------------------------------------------
`default_nettype none

module bhlfs_ctrl
  import bhlfs_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   start,
  input  wire logic   [1:0] func_i,
  input  wire sts_t   sts_i,
  output cmd_t        cmd_o,
  output logic        busy,
  output state_e      state_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (func_i)
            FUNC_ADD:   state_d = ST_ADD;
            FUNC_END:   state_d = ST_RD;
            FUNC_QUERY: state_d = ST_QRY;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD:   state_d = ST_IDLE;
      ST_QRY:   state_d = ST_IDLE;
      ST_RD:    state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_NORM;
      ST_NORM:  if (sts_i.x_top) state_d = ST_SQR;
      ST_SQR:   if (sts_i.sqr_last) state_d = ST_L10;
      ST_L10:   state_d = ST_SCORE;
      ST_SCORE: state_d = sts_i.bin_last ? ST_DCHK : ST_RD;
      ST_DCHK:  state_d = sts_i.max_zero ? ST_FIN : ST_DRD;
      ST_DRD:   state_d = ST_DLD;
      ST_DLD:   state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_last) state_d = sts_i.bin_last ? ST_FIN : ST_DRD;
      end
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.cnt_rd_in = 1'b1;
        cmd_o.cap_idx   = start;
        if (start && func_i == FUNC_END) begin
          cmd_o.bin_clr = 1'b1;
          cmd_o.max_clr = 1'b1;
          cmd_o.sum_clr = 1'b1;
        end
      end
      ST_ADD:   cmd_o.cnt_wr = 1'b1;
      ST_QRY:   cmd_o.out_query = 1'b1;
      ST_LOAD:  cmd_o.load_x = 1'b1;
      ST_NORM: begin
        cmd_o.norm   = !sts_i.x_top;
        cmd_o.load_m = sts_i.x_top;
      end
      ST_SQR:   cmd_o.sqr = 1'b1;
      ST_L10:   cmd_o.calc_l10 = 1'b1;
      ST_SCORE: begin
        cmd_o.calc_score = 1'b1;
        cmd_o.bin_inc    = 1'b1;
      end
      ST_DLD:   cmd_o.div_ld = 1'b1;
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.sum_add  = sts_i.div_last;
        cmd_o.bin_inc  = sts_i.div_last;
      end
      ST_FIN: begin
        cmd_o.out_fill  = 1'b1;
        cmd_o.clr_valid = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy    = (state_q != ST_IDLE);
  assign state_o = state_q;

endmodule

`default_nettype wire

// ----- design/bhlfs_dp.sv -----
// ----------------------------------------------------------------------------
// bhlfs_dp
// Datapath: bin counters, log unit, score store, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bhlfs_dp
  import bhlfs_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [BIN_W-1:0] byte_i,
  input  wire cmd_t cmd_i,
  output sts_t      sts_o,
  output rsp_t      rsp_o,
  output logic      done_o
);

  localparam int XW = COUNT_BITS + 1;
  localparam int EW = $clog2(XW);
  localparam int L2W = EW + 16;
  localparam int L10W = EW + 15;
  localparam int SCW = EW + 23;
  localparam int DW = SCORE_W + 9;

  // bin counters with per-entry valid bits
  logic [COUNT_BITS-1:0] cnt_mem [NUM_BINS];
  logic [NUM_BINS-1:0]   valid_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic                  cnt_vld_q;
  logic [COUNT_BITS-1:0] cnt_val;
  logic [BIN_W-1:0]      cnt_addr;
  logic [BIN_W-1:0]      idx_q;
  logic [BIN_W-1:0]      bin_q;

  assign cnt_addr = cmd_i.cnt_rd_in ? byte_i : bin_q;
  assign cnt_val  = cnt_vld_q ? cnt_rd_q : '0;

  always_ff @(posedge clk_i) begin
    cnt_rd_q  <= cnt_mem[cnt_addr];
    cnt_vld_q <= valid_q[cnt_addr];
    if (cmd_i.cnt_wr) begin
      cnt_mem[idx_q] <= (&cnt_val) ? cnt_val : cnt_val + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clr_valid) begin
      valid_q <= '0;
    end else if (cmd_i.cnt_wr) begin
      valid_q[idx_q] <= 1'b1;
    end
  end

  // log2 by normalize and repeated squaring
  logic [XW-1:0]        x_q;
  logic [EW-1:0]        e_q;
  logic [MANT_W-1:0]    m_q, m_d;
  logic [15:0]          frac_q;
  logic [STEP_W-1:0]    step_q;
  logic [XW+MANT_W-1:0] x_ext;
  logic [2*MANT_W-1:0]  sq_full;
  logic [MANT_W:0]      sq;
  logic [L2W-1:0]       l2;
  logic [L10W+15:0]     l10_full;
  logic [L10W-1:0]      l10_q;
  logic [SCW-1:0]       sc_full;
  logic [SCORE_W-1:0]   score_new;
  logic [SCORE_W-1:0]   max_q;

  assign x_ext     = {x_q, {MANT_W{1'b0}}};
  assign sq_full   = (2*MANT_W)'(m_q) * (2*MANT_W)'(m_q);
  assign sq        = sq_full[2*MANT_W-1:MANT_W-1];
  assign m_d       = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
  assign l2        = {e_q, frac_q};
  assign l10_full  = (L10W+16)'(l2) * (L10W+16)'(LOG10_2_Q16);
  assign sc_full   = SCW'(l10_q) * SCW'(100) + SCW'(32768);
  assign score_new = sc_full[16 +: SCORE_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= XW'(cnt_val) + 1'b1;
      e_q <= EW'(XW - 1);
    end else if (cmd_i.norm) begin
      x_q <= x_q << 1;
      e_q <= e_q - 1'b1;
    end
    if (cmd_i.load_m) begin
      m_q    <= x_ext[XW+MANT_W-1 -: MANT_W];
      frac_q <= '0;
      step_q <= '0;
    end else if (cmd_i.sqr) begin
      m_q    <= m_d;
      frac_q <= {frac_q[14:0], sq[MANT_W]};
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.calc_l10) begin
      l10_q <= l10_full[L10W+15:16];
    end
  end

  // score store, written in the first pass before any read
  logic [SCORE_W-1:0] sc_mem [NUM_BINS];
  logic [SCORE_W-1:0] sc_rd_q;

  always_ff @(posedge clk_i) begin
    sc_rd_q <= sc_mem[bin_q];
    if (cmd_i.calc_score) begin
      sc_mem[bin_q] <= score_new;
    end
  end

  // percentage divider, one quotient bit a cycle
  logic [DW-1:0]     rem_q;
  logic [DW-1:0]     den_k;
  logic [KCNT_W-1:0] k_q;
  logic [QUO_W-1:0]  quo_q;
  logic              q_bit;
  logic [QUO_W-1:0]  quo_next;
  logic [SUM_W-1:0]  sum_q;
  logic [SUM_W:0]    fill_full;

  assign den_k    = DW'(max_q) << (k_q + 1'b1);
  assign q_bit    = (rem_q >= den_k);
  assign quo_next = {quo_q[QUO_W-2:0], q_bit};
  assign fill_full = (SUM_W+1)'(sum_q) + (SUM_W+1)'(128);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_ld) begin
      rem_q <= DW'(sc_rd_q) * DW'(200) + DW'(max_q);
      k_q   <= KCNT_W'(QUO_W - 1);
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (q_bit) rem_q <= rem_q - den_k;
      k_q   <= k_q - 1'b1;
      quo_q <= quo_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_idx) idx_q <= byte_i;
    if (cmd_i.bin_clr) begin
      bin_q <= '0;
    end else if (cmd_i.bin_inc) begin
      bin_q <= bin_q + 1'b1;
    end
    if (cmd_i.max_clr) begin
      max_q <= '0;
    end else if (cmd_i.calc_score && score_new > max_q) begin
      max_q <= score_new;
    end
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
    end else if (cmd_i.sum_add) begin
      sum_q <= sum_q + SUM_W'(quo_next);
    end
  end

  // result register and strobe
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_query) begin
      rsp_o.fill_percent <= '0;
      rsp_o.bin_count    <= 32'(cnt_val);
    end else if (cmd_i.out_fill) begin
      rsp_o.fill_percent <= fill_full[PCT_W+7:8];
      rsp_o.bin_count    <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.out_query | cmd_i.out_fill;
    end
  end

  assign sts_o.x_top    = x_q[XW-1];
  assign sts_o.sqr_last = (step_q == STEP_W'(SQR_STEPS - 1));
  assign sts_o.div_last = (k_q == '0);
  assign sts_o.bin_last = (bin_q == BIN_W'(NUM_BINS - 1));
  assign sts_o.max_zero = (max_q == '0);

endmodule

`default_nettype wire

// ----- design/byte_histogram_log_fill_score.sv -----
// ----------------------------------------------------------------------------
// byte_histogram_log_fill_score
// Byte histogram with a log-scaled, max-normalised mean fill score.
// ----------------------------------------------------------------------------
// add: the accept cycle reads the bin counter, the busy ST_ADD state writes it
// query: the accept cycle reads the bin counter, the busy ST_QRY state registers
//   the result; result strobe in the first idle cycle
// end of file: per bin read, load, normalize shifts, 16 squaring steps, log10
//   and score; then per bin read, load and bit-serial divide, then the finish
//   state; the divide pass is skipped when every score is zero
// reset: async active low, clears the fsm, strobe and all counter valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module byte_histogram_log_fill_score
  import bhlfs_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire req_t req_i,
  output logic      busy,
  output rsp_t      rsp_o,
  output logic      done_o
);

  // command and status between the sequencer and datapath
  cmd_t   cmd;
  sts_t   sts;
  state_e state;

  // sequencer: decodes the request and walks the end-of-file passes
  bhlfs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .func_i  (req_i.func),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy    (busy),
    .state_o (state)
  );

  // datapath: counters, log unit, score store, divider, result register
  bhlfs_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (req_i.data_byte),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

  // a result strobe only follows a query or the end-of-file finish state
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state) == ST_QRY || $past(state) == ST_FIN))
    else $error("result strobe without a producing state");

  // a query result carries no fill score
  a_query_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(state) == ST_QRY) |-> (rsp_o.fill_percent == '0))
    else $error("query result with nonzero fill");

  // fill score stays a percentage
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.fill_percent <= 7'd100))
    else $error("fill percent above 100");

  // an accepted end request keeps the block busy on the next cycle
  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.func == FUNC_END) |=> busy)
    else $error("end request not started");

endmodule

`default_nettype wire

// ----- tb/sv/byte_histogram_log_fill_score_tb.sv -----
// ----------------------------------------------------------------------------
// byte_histogram_log_fill_score_tb
// Drives add, end-of-file, query and unused requests into the histogram
// block, checks each strobed result against the directed rows or its
// own fixed-point log scorer, field by field and in order.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_histogram_log_fill_score_tb
  import bhlfs_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 100000;  // one end of file walks all bins
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 725;

  logic clk_i;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  rsp_t rsp_o;
  logic done_o;

  byte_histogram_log_fill_score uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // predictor state: one counter per byte value
  logic [31:0] hist_bins [NUM_BINS];
  rsp_t        rsp_pending [$];
  int          fail_count;
  int          idle_cycles;

  // round(100*log10(count+1)) in q16 fixed point, via repeated squaring
  function automatic longint unsigned log_score_of(longint unsigned cnt);
    longint unsigned x;
    longint unsigned m;
    longint unsigned l2;
    longint unsigned l10;
    int unsigned     e;
    int unsigned     frac;
    x = cnt + 1;
    e = 0;
    frac = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    if (e <= 30) m = x << (30 - e);
    else         m = x >> (e - 30);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    l2  = (longint'(e) << 16) | frac;
    l10 = (l2 * LOG10_2_Q16) >> 16;
    return (100 * l10 + 64'h8000) >> 16;
  endfunction

  // end of file: mean of max-normalised scores, then clear the histogram
  function automatic logic [6:0] fill_score_and_clear();
    longint unsigned scores [NUM_BINS];
    longint unsigned top;
    longint unsigned sum;
    top = 0;
    sum = 0;
    for (int i = 0; i < NUM_BINS; i++) begin
      scores[i] = log_score_of(hist_bins[i]);
      if (scores[i] > top) top = scores[i];
    end
    // all-zero histogram gives zero without dividing
    if (top != 0)
      for (int i = 0; i < NUM_BINS; i++) sum += (200 * scores[i] + top) / (2 * top);
    for (int i = 0; i < NUM_BINS; i++) hist_bins[i] = '0;
    return 7'((2 * sum + NUM_BINS) / (2 * NUM_BINS));
  endfunction

  // update the histogram model; returns 1 with the expected response if any
  function automatic bit histogram_step(req_t r, output rsp_t rsp);
    rsp = '0;
    case (func_e'(r.func))
      FUNC_ADD: begin
        // counters saturate at all ones
        if (hist_bins[r.data_byte] != '1) hist_bins[r.data_byte]++;
        return 1'b0;
      end
      FUNC_END: begin
        rsp.fill_percent = fill_score_and_clear();
        return 1'b1;
      end
      FUNC_QUERY: begin
        rsp.bin_count = hist_bins[r.data_byte];
        return 1'b1;
      end
      default: return 1'b0;  // unused code is ignored
    endcase
  endfunction

  // directed stimulus; typed expectation only where obvious
  typedef struct {
    func_e      func;
    logic [7:0] data_byte;
    bit         typed;
    rsp_t       rsp;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{FUNC_QUERY, 8'd0,   1, '{7'd0, 32'd0}},   // empty bin after reset
    '{FUNC_QUERY, 8'd255, 1, '{7'd0, 32'd0}},
    '{FUNC_END,   8'd0,   1, '{7'd0, 32'd0}},   // all scores zero
    '{FUNC_NONE,  8'hff,  0, '{7'd0, 32'd0}},   // ignored code
    '{FUNC_ADD,   8'd255, 0, '{7'd0, 32'd0}},
    '{FUNC_ADD,   8'd255, 0, '{7'd0, 32'd0}},
    '{FUNC_ADD,   8'd255, 0, '{7'd0, 32'd0}},
    '{FUNC_QUERY, 8'd255, 1, '{7'd0, 32'd3}},
    '{FUNC_NONE,  8'd255, 0, '{7'd0, 32'd0}},   // must not touch the bin
    '{FUNC_QUERY, 8'd255, 1, '{7'd0, 32'd3}},
    '{FUNC_END,   8'd0,   0, '{7'd0, 32'd0}},   // single busy bin
    '{FUNC_QUERY, 8'd255, 1, '{7'd0, 32'd0}},   // cleared after end
    '{FUNC_ADD,   8'd0,   0, '{7'd0, 32'd0}},
    '{FUNC_ADD,   8'd1,   0, '{7'd0, 32'd0}},
    '{FUNC_ADD,   8'd128, 0, '{7'd0, 32'd0}},
    '{FUNC_ADD,   8'd128, 0, '{7'd0, 32'd0}},
    '{FUNC_ADD,   8'd85,  0, '{7'd0, 32'd0}},
    '{FUNC_ADD,   8'd170, 0, '{7'd0, 32'd0}},
    '{FUNC_QUERY, 8'd128, 0, '{7'd0, 32'd0}},
    '{FUNC_END,   8'd0,   0, '{7'd0, 32'd0}},
    '{FUNC_END,   8'd0,   1, '{7'd0, 32'd0}}    // back-to-back end, empty
  };

  // hands one request to the block, with an optional leading gap
  task automatic send_request(req_t r, int gap, bit typed, rsp_t typed_rsp);
    rsp_t pred;
    bit   has_rsp;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    has_rsp = histogram_step(r, pred);
    if (has_rsp) rsp_pending.push_back(typed ? typed_rsp : pred);
  endtask

  // gap length for the current idling phase
  function automatic int pick_gap(int phase);
    int pct;
    pct = (phase == 1) ? 83 : (phase == 3) ? 25 : 0;
    if ($urandom_range(99) < pct) return $urandom_range(1, 6);
    return 0;
  endfunction

  // result checker: done_o marks a one-cycle response
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (rsp_pending.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected response %p", rsp_o);
      end else begin
        exp_rsp = rsp_pending.pop_front();
        if (rsp_o.fill_percent !== exp_rsp.fill_percent ||
            rsp_o.bin_count !== exp_rsp.bin_count) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: fill exp %0d got %0d, count exp %0d got %0d",
                     exp_rsp.fill_percent, rsp_o.fill_percent,
                     exp_rsp.bin_count, rsp_o.bin_count);
        end
      end
    end
  end

  // watchdog: cycles with neither a request nor a response taken
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    req_t r;
    int   phase;
    int   sel;
    fail_count = 0;
    idle_cycles = 0;
    for (int i = 0; i < NUM_BINS; i++) hist_bins[i] = '0;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[k]) begin
      r.func = dir_rows[k].func;
      r.data_byte = dir_rows[k].data_byte;
      send_request(r, 0, dir_rows[k].typed, dir_rows[k].rsp);
    end

    // random part: mostly adds, some queries, rare ends
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / 60) % 4;
      if (n == RANDOM_ITEMS / 2) begin
        // hold off until every outstanding response has come back
        start <= 1'b0;
        @(posedge clk_i);
        while (rsp_pending.size() != 0) @(posedge clk_i);
      end
      sel = $urandom_range(99);
      if (sel < 3)       r.func = FUNC_NONE;
      else if (sel < 5)  r.func = FUNC_END;
      else if (sel < 22) r.func = FUNC_QUERY;
      else               r.func = FUNC_ADD;
      // half the bytes land in a few hot bins so counts build up
      if ($urandom_range(1)) r.data_byte = 8'($urandom);
      else                   r.data_byte = 8'($urandom_range(0, 7) * 37);
      send_request(r, pick_gap(phase), 1'b0, '0);
    end
    start <= 1'b0;

    // drain
    while (rsp_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && rsp_pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
